>>> design/mcc_pkg.sv
// Shared types and constants for the minimum coin change table unit.
// No dependencies.
package mcc_pkg;

  localparam int AMT_W     = 10;
  localparam int CNT_W     = 11;
  localparam int COIN_W    = 16;
  localparam int TBL_DEPTH = 1024;

  localparam logic [AMT_W-1:0] MAX_AMOUNT  = AMT_W'(TBL_DEPTH - 1);
  localparam logic [CNT_W-1:0] UNREACHABLE = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_EMIT
  } mcc_state_t;

  typedef struct packed {
    logic              wr_en;
    logic [AMT_W-1:0]  wr_addr;
    logic [AMT_W-1:0]  rd_addr_cur;
    logic [AMT_W-1:0]  rd_addr_prev;
  } mcc_ram_ctl_t;

endpackage

>>> design/min_coin_change_table_unit.sv
// Top level of the minimum coin change table unit: sequencer, table RAM, output register.
// Uses mcc_pkg, mcc_ram and mcc_relax.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata[15:0] coin_value, tlast last_coin
//  out_    | out | tvalid/tready      | tdata[9:0] min_coins, tuser reachable
//  cfg_    | in  | wr_en              | wr_data[9:0] target_amount
//
// A coin of value c in 1..1023 sweeps amounts c..1023, one per RAM cycle, then drains;
// other coin values are taken without a sweep.
// A last coin then reads the target, emits the result and clears the table.
// After reset the table is cleared before in_tready rises.
// A waiting result holds the block before the clearing pass; cfg writes are always taken.
module min_coin_change_table_unit import mcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] coin_value
  input  logic        in_tlast,   // last_coin
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] min_coins, [15:10] zero
  output logic        out_tuser,  // reachable
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data // [9:0] target_amount
);

  mcc_state_t         state_r, state_nxt;
  logic [AMT_W-1:0]   amt_r, amt_nxt;
  logic [AMT_W-1:0]   coin_r;
  logic               last_r;
  logic [AMT_W-1:0]   target_r;
  logic               s2_v_r, s2_vq_r;
  logic [AMT_W-1:0]   s2_addr_r;
  logic               out_valid_r;
  logic [AMT_W-1:0]   out_min_r;
  logic               out_reach_r;

  mcc_ram_ctl_t       ram_ctl;
  logic [CNT_W-1:0]   wr_data;
  logic [CNT_W-1:0]   rd_cur, rd_prev, relax_val;
  logic               in_acc;
  logic               coin_ok;
  logic               out_free;
  logic               fwd_en;

  assign in_acc   = in_tvalid && in_tready;
  assign coin_ok  = (in_tdata[COIN_W-1:AMT_W] == '0) && (in_tdata[AMT_W-1:0] != '0);
  assign out_free = !out_valid_r || out_tready;
  assign fwd_en   = (coin_r == AMT_W'(1)) && s2_vq_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (amt_r == MAX_AMOUNT) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (coin_ok) state_nxt = ST_SWEEP;
          else if (in_tlast) state_nxt = ST_READ;
        end
      end
      ST_SWEEP: if (amt_r == MAX_AMOUNT) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = last_r ? ST_READ : ST_IDLE;
      ST_READ:  state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready            = 1'b0;
    ram_ctl.wr_en        = s2_v_r;
    ram_ctl.wr_addr      = s2_addr_r;
    ram_ctl.rd_addr_cur  = amt_r;
    ram_ctl.rd_addr_prev = amt_r - coin_r;
    wr_data              = relax_val;
    amt_nxt              = amt_r;
    case (state_r)
      ST_CLEAR: begin
        ram_ctl.wr_en   = 1'b1;
        ram_ctl.wr_addr = amt_r;
        wr_data         = (amt_r == '0) ? '0 : UNREACHABLE;
        amt_nxt         = amt_r + AMT_W'(1);
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc && coin_ok) amt_nxt = in_tdata[AMT_W-1:0];
      end
      ST_SWEEP: amt_nxt = amt_r + AMT_W'(1);
      ST_DRAIN: ;
      ST_READ:  ram_ctl.rd_addr_cur = target_r;
      ST_EMIT: begin
        ram_ctl.rd_addr_cur = target_r;
        if (out_free) amt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      amt_r       <= '0;
      last_r      <= 1'b0;
      target_r    <= '0;
      s2_v_r      <= 1'b0;
      s2_vq_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      amt_r   <= amt_nxt;
      s2_v_r  <= (state_r == ST_SWEEP);
      s2_vq_r <= s2_v_r;
      if (cfg_wr_en) target_r <= cfg_wr_data;
      if (in_acc) last_r <= in_tlast;
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= amt_r;
    if (in_acc && coin_ok) coin_r <= in_tdata[AMT_W-1:0];
    if (state_r == ST_EMIT && out_free) begin
      out_reach_r <= (rd_cur != UNREACHABLE);
      out_min_r   <= (rd_cur != UNREACHABLE) ? rd_cur[AMT_W-1:0] : '0;
    end
  end

  mcc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_ctl.wr_en),
    .wr_addr   (ram_ctl.wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (ram_ctl.rd_addr_cur),
    .rd_addr_b (ram_ctl.rd_addr_prev),
    .rd_data_a (rd_cur),
    .rd_data_b (rd_prev)
  );

  mcc_relax u_relax (
    .clk        (clk),
    .fwd_en     (fwd_en),
    .cur_count  (rd_cur),
    .prev_count (rd_prev),
    .new_count  (relax_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(16 - AMT_W)'(0), out_min_r};
  assign out_tuser  = out_reach_r;

endmodule

>>> design/mcc_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Read during a write to the same address returns the old data. No dependencies.
module mcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule

>>> design/mcc_relax.sv
// Relaxation step of the sweep: best = min(best, best[a - coin] + 1),
// with forwarding of the last value written, for a coin of value 1. Uses mcc_pkg.
module mcc_relax import mcc_pkg::*; (
  input  logic             clk,
  input  logic             fwd_en,
  input  logic [CNT_W-1:0] cur_count,
  input  logic [CNT_W-1:0] prev_count,
  output logic [CNT_W-1:0] new_count
);

  logic [CNT_W-1:0] last_val_r;
  logic [CNT_W-1:0] prev_sel;
  logic [CNT_W-1:0] cand;
  logic             take;

  always_comb begin
    prev_sel  = fwd_en ? last_val_r : prev_count;
    cand      = prev_sel + CNT_W'(1);
    // candidate at or above the marker is dropped
    take      = (prev_sel < (UNREACHABLE - CNT_W'(1))) && (cand < cur_count);
    new_count = take ? cand : cur_count;
  end

  always_ff @(posedge clk) begin
    last_val_r <= new_count;
  end

endmodule

>>> test/min_coin_change_table_unit_test.sv
// Self-checking bench for min_coin_change_table_unit: coin sets in, fewest-coin answers out.
// Keeps its own copy of the best-count table and compares each result beat with it.
// Depends on mcc_pkg and the RTL only.
module min_coin_change_table_unit_test;
  import mcc_pkg::*;

  localparam int SETTLE_CYCLES = 1100;
  localparam int HOLD_CYCLES   = 3000;
  localparam int QUIET_LIMIT   = 20000;
  localparam int RANDOM_COINS  = 580;
  localparam int DIR_ROWS      = 25;

  typedef struct packed {
    logic [AMT_W-1:0] min_coins;
    logic             reachable;
  } coin_result_t;

  typedef struct packed {
    logic              set_target;
    logic [AMT_W-1:0]  target;
    logic [COIN_W-1:0] coin;
    logic              last;
    logic              typed;
    coin_result_t      answer;
  } coin_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] coin_value
  logic        in_tlast;   // last_coin
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [9:0] min_coins, [15:10] zero
  logic        out_tuser;  // reachable
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data; // [9:0] target_amount

  logic [CNT_W-1:0] best_tab [TBL_DEPTH];
  logic [AMT_W-1:0] cur_target;
  coin_result_t     pending_answers [$];
  coin_row_t        dir_rows [DIR_ROWS];
  bit               failed;
  int               burst_left;
  int               in_beats;
  int               quiet_cycles;

  min_coin_change_table_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void wipe_table();
    best_tab[0] = '0;
    for (int a = 1; a < TBL_DEPTH; a++) best_tab[a] = UNREACHABLE;
  endfunction

  // One coin sweeps the table in rising order; a last coin reads the target and clears.
  function automatic bit fewest_coins_step(input logic [COIN_W-1:0] coin, input logic last,
                                           output coin_result_t res);
    int unsigned cand;
    res = '0;
    if (coin != 0 && coin <= MAX_AMOUNT) begin
      for (int unsigned a = coin; a < TBL_DEPTH; a++) begin
        cand = best_tab[a - coin] + 1;
        if (best_tab[a - coin] != UNREACHABLE && cand < UNREACHABLE && cand < best_tab[a])
          best_tab[a] = CNT_W'(cand);
      end
    end
    if (!last) return 1'b0;
    if (best_tab[cur_target] != UNREACHABLE) begin
      res.min_coins = best_tab[cur_target][AMT_W-1:0];
      res.reachable = 1'b1;
    end
    wipe_table();
    return 1'b1;
  endfunction

  function automatic coin_row_t row(input bit set_t, input int t, input int coin,
                                    input bit last, input bit typed, input int m, input bit r);
    coin_row_t x;
    x.set_target       = set_t;
    x.target           = AMT_W'(t);
    x.coin             = COIN_W'(coin);
    x.last             = last;
    x.typed            = typed;
    x.answer.min_coins = AMT_W'(m);
    x.answer.reachable = r;
    return x;
  endfunction

  function automatic logic [COIN_W-1:0] pick_coin();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return COIN_W'($urandom_range(1, 40));
    if (r < 16) return COIN_W'($urandom_range(41, 1023));
    return COIN_W'($urandom_range(1024, 65535));
  endfunction

  function automatic logic [AMT_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MAX_AMOUNT;
      2:       return AMT_W'($urandom_range(1, 30));
      default: return AMT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Bursts of random length separated by gaps: none, short or long.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(100, 1500);
        default: gap = $urandom_range(1, 40);
      endcase
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_coin(input logic [COIN_W-1:0] coin, input logic last,
                           input bit typed, input coin_result_t typed_ans);
    coin_result_t res;
    pace();
    in_tvalid <= 1'b1;
    in_tdata  <= coin;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    in_beats++;
    if (fewest_coins_step(coin, last, res))
      pending_answers.push_back(typed ? typed_ans : res);
  endtask

  // Target changes only once every answer is out and the block has had time to settle.
  task automatic retarget(input logic [AMT_W-1:0] t);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_target = t;
  endtask

  initial begin : stimulus
    int sets;
    int n;
    logic [COIN_W-1:0] coin;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    failed      = 1'b0;
    burst_left  = 0;
    in_beats    = 0;
    cur_target  = '0;
    wipe_table();
    dir_rows = '{
      row(0, 0,    1,      1, 1, 0,    1),  // target zero after reset
      row(1, 1023, 1,      1, 1, 1023, 1),  // most coins possible
      row(0, 0,    2,      1, 1, 0,    0),  // odd target, even coin
      row(0, 0,    65535,  1, 1, 0,    0),  // oversized coin only
      row(0, 0,    1024,   0, 0, 0,    0),
      row(0, 0,    1023,   1, 1, 1,    1),
      row(1, 7,    2,      0, 0, 0,    0),
      row(0, 0,    32768,  0, 0, 0,    0),
      row(0, 0,    3,      1, 0, 0,    0),
      row(1, 10,   1,      0, 0, 0,    0),
      row(0, 0,    5,      0, 0, 0,    0),
      row(0, 0,    6,      1, 0, 0,    0),
      row(1, 0,    5,      1, 1, 0,    1),
      row(1, 512,  512,    1, 1, 1,    1),
      row(0, 0,    16'hAAAA, 0, 0, 0,  0),
      row(0, 0,    16'h5555, 0, 0, 0,  0),
      row(0, 0,    256,    1, 0, 0,    0),
      row(1, 5,    4,      0, 0, 0,    0),
      row(0, 0,    6,      1, 1, 0,    0),  // unreachable target
      row(1, 15,   7,      0, 0, 0,    0),
      row(0, 0,    5,      0, 0, 0,    0),
      row(0, 0,    3,      1, 0, 0,    0),
      row(1, 1000, 999,    0, 0, 0,    0),
      row(0, 0,    300,    0, 0, 0,    0),
      row(0, 0,    100,    1, 0, 0,    0)
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_target) retarget(dir_rows[i].target);
      send_coin(dir_rows[i].coin, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].answer);
    end

    sets = 0;
    while (in_beats < DIR_ROWS + RANDOM_COINS) begin
      if (sets % 6 == 0) retarget(pick_target());
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        coin = pick_coin();
        send_coin(coin, k == n - 1, 1'b0, '0);
      end
      sets++;
    end

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && pending_answers.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Receiver: free-running and randomly stalling stretches chosen at random, plus two long holds.
  initial begin : sink
    int mode_left;
    int holds_done;
    bit free_run;
    out_tready = 1'b0;
    mode_left  = 0;
    holds_done = 0;
    free_run   = 1'b1;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (holds_done < 2 && out_tvalid && in_beats >= (holds_done == 0 ? 100 : 350)) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          free_run  = $urandom_range(0, 2) == 0;
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        out_tready <= free_run ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin : result_check
    coin_result_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result beat: min_coins %0d reachable %0b",
               out_tdata[AMT_W-1:0], out_tuser);
        failed = 1'b1;
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[AMT_W-1:0] !== want.min_coins) begin
          $error("min_coins: expected %0d, got %0d", want.min_coins, out_tdata[AMT_W-1:0]);
          failed = 1'b1;
        end
        if (out_tuser !== want.reachable) begin
          $error("reachable: expected %0b, got %0b", want.reachable, out_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

endmodule
